// ===== src/utf8_codepoint_decoder_core_defines.svh =====
// Assertion helpers for the decoder core RTL.
`ifndef UTF8_CODEPOINT_DECODER_CORE_DEFINES_SVH
`define UTF8_CODEPOINT_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8CPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8CPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

// ===== src/u8cpd_pkg.sv =====
package u8cpd_pkg;

  localparam int unsigned PosBits  = 16;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned CpBits   = 32;
  localparam int unsigned MaxAvail = 7;

  typedef logic [PosBits-1:0]  pos_t;
  typedef logic [ByteBits-1:0] byte_t;
  typedef logic [CpBits-1:0]   cp_t;
  typedef logic [2:0]          len_t;

  // Lead and continuation byte patterns
  localparam byte_t ContMask  = 8'hC0;
  localparam byte_t ContTag   = 8'h80;
  localparam byte_t Lead2Mask = 8'hE0;
  localparam byte_t Lead2Tag  = 8'hC0;
  localparam byte_t Lead3Mask = 8'hF0;
  localparam byte_t Lead3Tag  = 8'hE0;
  localparam byte_t Lead4Mask = 8'hF8;
  localparam byte_t Lead4Tag  = 8'hF0;

  // Surrogate repair constants
  localparam cp_t LowSurFirst  = 32'h0000_DC00;
  localparam cp_t LowSurLast   = 32'h0000_DFFF;
  localparam cp_t HighSurFirst = 32'h0000_D800;
  localparam cp_t SuppBase     = 32'h0001_0000;

  localparam len_t LenNone = 3'd0;
  localparam len_t Len3    = 3'd3;

  typedef struct packed {
    len_t len;  // zero on failure
    cp_t  cp;
  } seq_t;

  typedef struct packed {
    byte_t window_byte0;
    byte_t window_byte1;
    byte_t window_byte2;
    byte_t window_byte3;
    byte_t window_byte4;
    byte_t window_byte5;
    byte_t window_byte6;
    pos_t  start_position;
    pos_t  end_position;
  } in_t;

  typedef struct packed {
    logic decode_ok;
    cp_t  code_point;
    pos_t next_position;
  } out_t;

  function automatic logic is_cont(byte_t b);
    return (b & ContMask) == ContTag;
  endfunction

endpackage

// ===== src/u8cpd_seq_decode.sv =====
module u8cpd_seq_decode (
  input  u8cpd_pkg::byte_t [3:0] seq_bytes_i,  // [0] is the lead byte
  input  logic [3:0]             avail_ge_i,   // bit k: at least k+1 bytes left
  output u8cpd_pkg::seq_t        seq_o
);
  import u8cpd_pkg::*;

  byte_t b0, b1, b2, b3;

  assign b0 = seq_bytes_i[0];
  assign b1 = seq_bytes_i[1];
  assign b2 = seq_bytes_i[2];
  assign b3 = seq_bytes_i[3];

  always_comb begin
    seq_o.len = LenNone;
    seq_o.cp  = '0;
    if (avail_ge_i[0]) begin
      if (!b0[7]) begin
        seq_o.len = 3'd1;
        seq_o.cp  = cp_t'(b0);
      end else if ((b0 & Lead2Mask) == Lead2Tag) begin
        if (avail_ge_i[1] && is_cont(b1)) begin
          seq_o.len = 3'd2;
          seq_o.cp  = cp_t'({b0[4:0], b1[5:0]});
        end
      end else if ((b0 & Lead3Mask) == Lead3Tag) begin
        if (avail_ge_i[2] && is_cont(b1) && is_cont(b2)) begin
          seq_o.len = Len3;
          seq_o.cp  = cp_t'({b0[3:0], b1[5:0], b2[5:0]});
        end
      end else if ((b0 & Lead4Mask) == Lead4Tag) begin
        if (avail_ge_i[3] && is_cont(b1) && is_cont(b2) && is_cont(b3)) begin
          seq_o.len = 3'd4;
          seq_o.cp  = cp_t'({b0[2:0], b1[5:0], b2[5:0], b3[5:0]});
        end
      end
    end
  end

endmodule

// ===== src/utf8_codepoint_decoder_core.sv =====
// UTF-8 code point decoder core.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one transaction carries
// a seven-byte window of the text buffer plus the start and end positions.
// Output channel (out_valid_o / out_ready_i / out_data_o): one transaction per
// input transaction, in order, with decode_ok, code_point and next_position.
// On any failure (empty or truncated input, bad lead or continuation byte,
// failing second half of a repaired surrogate pair) decode_ok is 0, the code
// point is 0 and next_position equals start_position.
// A low surrogate from a three-byte sequence with three or more bytes behind
// it is merged with the following sequence (one level, modulo 2^32).
//
// An input register feeds one pass of decode logic into the result register.
// Throughput is one transaction per cycle unless stalled; the slowest
// path is the second sequence decode feeding the surrogate merge adders.
// Reset clears both valid flags, so the block comes up empty and ready.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; in_ready_o drops only once both are full.
`include "utf8_codepoint_decoder_core_defines.svh"

module utf8_codepoint_decoder_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  u8cpd_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output u8cpd_pkg::out_t out_data_o
);
  import u8cpd_pkg::*;

  // Pipeline registers
  in_t  in_q;
  logic in_valid_q, in_valid_d;
  out_t res_q, res_d;
  logic out_valid_q, out_valid_d;

  logic out_free;   // result register can take a new value this cycle
  logic advance;    // move the input register into the result register

  // Decode signals
  pos_t             span;
  logic             span_pos;
  logic [MaxAvail:1] avail_ge;
  byte_t [3:0]      first_bytes, second_bytes;
  seq_t             first_seq, second_seq;
  logic             merge;
  len_t             total_len;
  cp_t              merged_cp;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = out_free ? in_valid_q : out_valid_q;

  // ---------------------------------------------------------------------------
  // Available byte count, as thresholds
  // ---------------------------------------------------------------------------
  assign span_pos = in_q.end_position > in_q.start_position;
  assign span     = in_q.end_position - in_q.start_position;

  always_comb begin
    for (int k = 1; k <= MaxAvail; k++) begin
      avail_ge[k] = span_pos && (span >= pos_t'(k));
    end
  end

  // ---------------------------------------------------------------------------
  // Two sequence decoders: one at the start, one three bytes in
  // ---------------------------------------------------------------------------
  assign first_bytes  = {in_q.window_byte3, in_q.window_byte2,
                         in_q.window_byte1, in_q.window_byte0};
  assign second_bytes = {in_q.window_byte6, in_q.window_byte5,
                         in_q.window_byte4, in_q.window_byte3};

  u8cpd_seq_decode u_first (
    .seq_bytes_i (first_bytes),
    .avail_ge_i  (avail_ge[4:1]),
    .seq_o       (first_seq)
  );

  // Bytes left after the first sequence are avail - 3, hence the shift by 3.
  u8cpd_seq_decode u_second (
    .seq_bytes_i (second_bytes),
    .avail_ge_i  (avail_ge[7:4]),
    .seq_o       (second_seq)
  );

  // Merge a broken low surrogate with the sequence behind it
  assign merge = (first_seq.len == Len3) && (first_seq.cp >= LowSurFirst) &&
                 (first_seq.cp <= LowSurLast) && avail_ge[6];

  assign merged_cp = SuppBase + (first_seq.cp - LowSurFirst) +
                     ((second_seq.cp - HighSurFirst) << 10);

  always_comb begin
    total_len = first_seq.len;
    if (merge) begin
      // drop the whole item if the second half fails
      total_len = (second_seq.len == LenNone) ? LenNone : Len3 + second_seq.len;
    end
  end

  always_comb begin
    res_d.decode_ok     = total_len != LenNone;
    res_d.code_point    = '0;
    res_d.next_position = in_q.start_position;
    if (total_len != LenNone) begin
      res_d.code_point    = merge ? merged_cp : first_seq.cp;
      res_d.next_position = in_q.start_position + pos_t'(total_len);
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: capture on acceptance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `U8CPD_ASSERT_NOW(a_ready_when_drained, clk_i, rst_ni, out_ready_i, in_ready_o)
  `U8CPD_ASSERT_NEXT(a_item_reaches_output, clk_i, rst_ni, advance, out_valid_o)
  `U8CPD_ASSERT_NOW(a_error_zero_cp, clk_i, rst_ni,
                    out_valid_o && !out_data_o.decode_ok, out_data_o.code_point == '0)

endmodule
